[hw/rtl/swhc_pkg.sv]
// shared constants and types for the sliding window hit counter
// no dependencies; compiled first
package swhc_pkg;

  localparam int TS_W           = 31;
  localparam int COUNT_W        = 16;
  localparam int TOTAL_W        = 25;
  localparam int WINDOW_DEFAULT = 300;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic CMD_HIT   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [TS_W-1:0]    second;
    logic [COUNT_W-1:0] count;
  } bucket_t;

endpackage

[hw/rtl/swhc_if.sv]
// request and response channel interfaces, valid/ready handshake
// depends on swhc_pkg
interface swhc_req_if;
  import swhc_pkg::*;
  logic            valid;
  logic            ready;
  logic            cmd;
  logic [TS_W-1:0] timestamp;
  modport source (output valid, output cmd, output timestamp, input ready);
  modport sink   (input valid, input cmd, input timestamp, output ready);
endinterface

interface swhc_rsp_if;
  import swhc_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] hit_total;
  modport source (output valid, output hit_total, input ready);
  modport sink   (input valid, input hit_total, output ready);
endinterface

[hw/rtl/swhc_slot_mod.sv]
// timestamp modulo the window size by reciprocal multiplication
// depends on swhc_pkg; three pipelined stages: multiply, scale back, subtract
module swhc_slot_mod #(
  parameter int WINDOW = swhc_pkg::WINDOW_DEFAULT,
  parameter int AW     = $clog2(WINDOW)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [swhc_pkg::TS_W-1:0] value,
  output logic                  done,
  output logic [AW-1:0]         slot
);
  import swhc_pkg::*;

  localparam int SHIFT = TS_W + $clog2(WINDOW);
  localparam int PW    = 2 * TS_W + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW);
  localparam logic [TS_W:0] RECIP = RECIP_FULL[TS_W:0];

  logic [2:0]      stage;
  logic [TS_W-1:0] val;
  logic [TS_W-1:0] quo;
  logic [TS_W-1:0] qd;
  logic [AW-1:0]   rem;
  logic [PW-1:0]   prod;

  // ceil(2^SHIFT / WINDOW) gives the exact quotient for every timestamp value
  always_comb begin
    prod = PW'(val) * PW'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[1:0], start};
      done  <= stage[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val <= value;
    end
    if (stage[0]) begin
      quo <= TS_W'(prod >> SHIFT);
    end
    if (stage[1]) begin
      qd <= quo * TS_W'(WINDOW);
    end
    if (stage[2]) begin
      rem <= AW'(val - qd);
    end
  end

  assign slot = rem;

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (AW+1)'(slot) < (AW+1)'(WINDOW))
    else $error("slot out of window range");

  a_done_after_stages: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(stage[2]))
    else $error("done without a reduction in flight");

  a_start_when_empty: assert property (@(posedge clk) disable iff (rst)
    start |-> (stage == 3'b000))
    else $error("new reduction started while one is in flight");

endmodule

[hw/rtl/swhc_bucket_ram.sv]
// bucket ring storage: one write port, one read port, registered read data
// depends on swhc_pkg for the bucket word type
module swhc_bucket_ram #(
  parameter int DEPTH = swhc_pkg::WINDOW_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  swhc_pkg::bucket_t wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output swhc_pkg::bucket_t rd_data
);
  import swhc_pkg::*;

  bucket_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // the sequencer never reads and writes one entry in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en && wr_addr == rd_addr))
    else $error("read and write to the same bucket in one cycle");

endmodule

[hw/rtl/sliding_window_hit_counter_unit.sv]
// channel  dir  payload                      handshake
// req      in   cmd (1), timestamp (31)      valid/ready
// rsp      out  hit_total (25)               valid/ready
//
// a hit goes through the 3-stage reciprocal-multiply modulo of the timestamp, then a bucket read and write
// a query reads every bucket, one bucket read per cycle on the single ram read port
// after rst a clearing pass over all WINDOW buckets empties them; req.ready stays low
// one word in flight at a time; a finished total waits in the rsp register while
// the next word is taken, and a query result stalls only if that register is still full
// depends on swhc_pkg, swhc_if, swhc_slot_mod, swhc_bucket_ram
module sliding_window_hit_counter_unit #(
  parameter int WINDOW = swhc_pkg::WINDOW_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  swhc_req_if.sink   req,
  swhc_rsp_if.source rsp
);
  import swhc_pkg::*;

  localparam int AW    = $clog2(WINDOW);
  localparam int SUM_W = COUNT_W + $clog2(WINDOW);
  localparam int CMP_W = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MOD, ST_HIT_RD, ST_HIT_WR, ST_SCAN, ST_DRAIN
  } state_t;

  state_t             state;
  logic [AW-1:0]      idx;
  logic [TS_W-1:0]    ts;
  logic               rd_vld;
  logic               acc_vld;
  logic [COUNT_W-1:0] add_val;
  logic [SUM_W-1:0]   sum;
  logic               out_valid;
  logic [TOTAL_W-1:0] total;

  logic               accept;
  logic               mod_start;
  logic               mod_done;
  logic [AW-1:0]      slot;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  bucket_t            wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  bucket_t            rd_data;
  logic [TS_W:0]      age;
  logic               in_window;
  logic               same_second;
  logic [TOTAL_W-1:0] total_sat;
  logic               drain_done;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign mod_start = accept && (req.cmd == CMD_HIT);

  swhc_slot_mod #(.WINDOW(WINDOW), .AW(AW)) u_slot_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (req.timestamp),
    .done  (mod_done),
    .slot  (slot)
  );

  swhc_bucket_ram #(.DEPTH(WINDOW), .AW(AW)) u_bucket_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // bucket counts when its tag lies in (ts - WINDOW, ts]
  always_comb begin
    age         = {1'b0, ts} - {1'b0, rd_data.second};
    in_window   = rd_data.valid && !age[TS_W] && (age[TS_W-1:0] < TS_W'(WINDOW));
    same_second = rd_data.valid && (rd_data.second == ts);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = slot;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = idx;
      end
      ST_HIT_RD: begin
        rd_en = 1'b1;
      end
      ST_HIT_WR: begin
        wr_en          = 1'b1;
        wr_data.valid  = 1'b1;
        wr_data.second = ts;
        if (!same_second) begin
          wr_data.count = COUNT_W'(1);
        end else if (rd_data.count == COUNT_MAX) begin
          wr_data.count = rd_data.count;
        end else begin
          wr_data.count = rd_data.count + COUNT_W'(1);
        end
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = idx;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (CMP_W'(sum) > CMP_W'(TOTAL_MAX)) begin
      total_sat = TOTAL_MAX;
    end else begin
      total_sat = TOTAL_W'(sum);
    end
    drain_done = !rd_vld && !acc_vld && (!out_valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      rd_vld    <= 1'b0;
      acc_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // read data comes back in the cycle after the read, then gets masked, then summed
      rd_vld  <= (state == ST_SCAN);
      acc_vld <= rd_vld;
      if (rd_vld) begin
        add_val <= in_window ? rd_data.count : '0;
      end
      if (acc_vld) begin
        sum <= sum + SUM_W'(add_val);
      end
      if (state == ST_DRAIN && drain_done) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (idx == AW'(WINDOW-1)) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            ts  <= req.timestamp;
            idx <= '0;
            sum <= '0;
            state <= (req.cmd == CMD_QUERY) ? ST_SCAN : ST_MOD;
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            state <= ST_HIT_RD;
          end
        end
        ST_HIT_RD: begin
          state <= ST_HIT_WR;
        end
        ST_HIT_WR: begin
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (idx == AW'(WINDOW-1)) begin
            idx   <= '0;
            state <= ST_DRAIN;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        ST_DRAIN: begin
          if (drain_done) begin
            total <= total_sat;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.hit_total = total;

  a_acc_only_in_query: assert property (@(posedge clk) disable iff (rst)
    acc_vld |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("bucket sum moved outside a query");

  a_rsp_from_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DRAIN))
    else $error("response raised without a finished query");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !accept && !rd_en)
    else $error("bucket access during clearing pass");

endmodule
